// ===== rtl/core/assert_macros.svh =====
// assertion macros for the allocator rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define SCA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SCA_ASSERT(lbl, clk, rst, prop)
`define SCA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/sca_pkg.sv =====
// shared constants, codes and types of the slab class allocator
// no dependencies
package sca_pkg;

   localparam int PAGE_BYTES   = 4096;
   localparam int REGION_PAGES = 16;
   localparam int CLASS_COUNT  = 32;
   localparam int ALIGN_BYTES  = 8;
   localparam int FIRST_CLASS  = 1;
   localparam int REGION_BYTES = PAGE_BYTES * REGION_PAGES;
   localparam int LINK_DEPTH   = REGION_BYTES / ALIGN_BYTES;

   localparam int CLS_W   = $clog2(CLASS_COUNT);
   localparam int LINK_W  = $clog2(LINK_DEPTH);
   localparam int ALIGN_W = $clog2(ALIGN_BYTES);
   localparam int CHUNK_W = 14;
   localparam int CPP_W   = $clog2(PAGE_BYTES + 1);
   localparam int SPAN_W  = 17;
   localparam int GROW_W  = 11;
   localparam int PROD_W  = CHUNK_W + GROW_W;
   localparam int CNT_W   = 14;
   localparam int PAGES_W = 5;
   localparam int TOTAL_W = 32;

   localparam logic [PROD_W-1:0]  GROW_LIMIT = PROD_W'(PAGE_BYTES * 256);
   localparam logic [CLS_W-1:0]   LAST_SLOT  = CLS_W'(CLASS_COUNT - 1);
   localparam logic [SPAN_W-1:0]  REGION_SPAN = SPAN_W'(REGION_BYTES);
   localparam logic [PAGES_W-1:0] PAGES_MAX  = '1;

   typedef enum logic [1:0] {
      RT_ALLOC  = 2'd0,
      RT_FREE   = 2'd1,
      RT_ADJUST = 2'd2,
      RT_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_SIZE      = 2'd1,
      ST_OOM       = 2'd2,
      ST_BAD_CLASS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_BASE   = 2'd0,
      CSR_GROWTH = 2'd1,
      CSR_LIMIT  = 2'd2,
      CSR_NONE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             building;
      logic [CLS_W-1:0] last_class;
   } table_info_type;

   typedef struct packed {
      logic [LINK_W-1:0]  head;
      logic [CNT_W-1:0]   free_count;
      logic [PAGES_W-1:0] page_count;
      logic [TOTAL_W-1:0] requested;
   } class_entry_type;

endpackage

// ===== rtl/core/slab_class_allocator_top.sv =====
// slab class allocator top level: request sequencer, class state memory, link memory
// depends on sca_pkg, sca_class_table and assert_macros.svh
// steps: size zero or bad class answer from idle; free and adjust run read, exec, write-back;
// allocate runs class scan, read, exec, pop, pop2, write-back; a new page adds page check and chunk walk
// throughput: one item at a time; busy drops as the result strobe rises; no receiver stall
// reset: synchronous; the table rebuild after reset holds busy, as a config write does
`include "assert_macros.svh"
module slab_class_allocator_top
   import sca_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic [15:0]         req_size_bytes,
   input  logic [15:0]         req_chunk_address,
   input  logic [5:0]          req_class_id,
   input  logic [15:0]         req_old_bytes,
   input  logic [15:0]         req_new_bytes,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [15:0]         rsp_granted_address,
   output logic [5:0]          rsp_chosen_class,
   output logic [31:0]         rsp_requested_total,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [16:0]         csr_write_data
);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_SCAN = 9'b000000010,
      S_READ = 9'b000000100,
      S_EXEC = 9'b000001000,
      S_PCHK = 9'b000010000,
      S_WALK = 9'b000100000,
      S_POP  = 9'b001000000,
      S_POP2 = 9'b010000000,
      S_WB   = 9'b100000000
   } state_type;

   // configuration registers
   logic [12:0]        base_ff;
   logic [GROW_W-1:0]  growth_ff;
   logic [SPAN_W-1:0]  limit_ff;
   logic               rebuild;

   // class table
   logic [CHUNK_W-1:0] tbl_chunk;
   logic [CPP_W-1:0]   tbl_cpp;
   table_info_type     tbl_info;

   // sequencer
   state_type          state_ff, state_in;
   req_kind_type       kind_ff;
   logic [15:0]        size_ff, caddr_ff, old_ff, new_ff;
   logic [CLS_W-1:0]   cls_ff, cls_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PAGES_W-1:0] pages_ff, pages_in;
   logic [TOTAL_W-1:0] reqd_ff, reqd_in;
   logic [SPAN_W-1:0]  len_ff, len_in;
   logic [SPAN_W-1:0]  walk_ff, walk_in;
   logic [CPP_W-1:0]   x_ff, x_in;
   logic [15:0]        grant_ff, grant_in;
   logic [SPAN_W-1:0]  bump_ff, bump_in;
   logic [SPAN_W-1:0]  paged_ff, paged_in;
   logic               accept;
   logic               bad_id;
   logic [SPAN_W-1:0]  avail;
   logic [SPAN_W:0]    paged_sum;
   logic [SPAN_W:0]    len_round;
   logic [SPAN_W:0]    step_len;
   logic               over_limit;

   // result registers
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [15:0]        rsp_grant_ff, rsp_grant_in;
   logic [5:0]         rsp_class_ff, rsp_class_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   // class state memory, one entry per class, valid bits stand in for reset
   class_entry_type    cmem [CLASS_COUNT];
   logic [CLASS_COUNT-1:0] cvalid_ff;
   class_entry_type    crd_ff;
   logic               crd_valid_ff;
   logic [CLS_W-1:0]   crd_addr;
   logic               cwr_en;
   class_entry_type    cwr_data;

   // link memory, next pointer per aligned chunk slot
   logic [LINK_W-1:0]  lmem [LINK_DEPTH];
   logic [LINK_W-1:0]  lrd_ff;
   logic               lwr_en;
   logic [LINK_W-1:0]  lwr_addr;

   assign rebuild = csr_write_enable && (csr_index != CSR_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= 13'd96;
         growth_ff <= GROW_W'(320);
         limit_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE:   base_ff   <= csr_write_data[12:0];
            CSR_GROWTH: growth_ff <= csr_write_data[GROW_W-1:0];
            CSR_LIMIT:  limit_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   sca_class_table u_table (
      .clock            (clock),
      .reset            (reset),
      .rebuild          (rebuild),
      .base_chunk_bytes (base_ff),
      .growth_factor_q8 (growth_ff),
      .rd_index         (cls_ff),
      .rd_chunk         (tbl_chunk),
      .rd_cpp           (tbl_cpp),
      .info             (tbl_info)
   );

   assign busy   = (state_ff != S_IDLE) || tbl_info.building;
   assign accept = start && !busy;
   assign bad_id = (req_class_id < 6'(FIRST_CLASS)) ||
                   (req_class_id > {1'b0, tbl_info.last_class});

   // page admission: region space left, byte cap, rounded bump step
   assign avail      = REGION_SPAN - bump_ff;
   assign paged_sum  = {1'b0, paged_ff} + {1'b0, len_ff};
   assign over_limit = (limit_ff != '0) && (paged_sum > {1'b0, limit_ff}) && (pages_ff != '0);
   assign len_round  = ({1'b0, len_ff} + (SPAN_W+1)'(ALIGN_BYTES - 1)) >> ALIGN_W << ALIGN_W;
   assign step_len   = (len_round > {1'b0, avail}) ? {1'b0, avail} : len_round;

   assign crd_addr = (state_ff == S_IDLE) ? req_class_id[CLS_W-1:0] : cls_ff;

   always_comb begin
      state_in      = state_ff;
      cls_in        = cls_ff;
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      pages_in      = pages_ff;
      reqd_in       = reqd_ff;
      len_in        = len_ff;
      walk_in       = walk_ff;
      x_in          = x_ff;
      grant_in      = grant_ff;
      bump_in       = bump_ff;
      paged_in      = paged_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_total_in  = rsp_total_ff;
      cwr_en        = 1'b0;
      cwr_data      = '{head: head_ff, free_count: cnt_ff,
                        page_count: pages_ff, requested: reqd_ff};
      lwr_en        = 1'b0;
      lwr_addr      = walk_ff[ALIGN_W +: LINK_W];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               grant_in = '0;
               if (req_kind_type'(req_type) == RT_ALLOC) begin
                  if (req_size_bytes == '0) begin
                     // size zero answers at once
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_SIZE;
                     rsp_grant_in  = '0;
                     rsp_class_in  = '0;
                     rsp_total_in  = '0;
                  end else begin
                     cls_in   = CLS_W'(FIRST_CLASS);
                     state_in = S_SCAN;
                  end
               end else if (req_kind_type'(req_type) == RT_NONE || bad_id) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_BAD_CLASS;
                  rsp_grant_in  = '0;
                  rsp_class_in  = '0;
                  rsp_total_in  = '0;
               end else begin
                  cls_in   = req_class_id[CLS_W-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_SCAN: begin
            // one class compared per cycle; the memory read follows the scan index
            if ({2'b0, tbl_chunk} >= size_ff) begin
               state_in = S_READ;
            end else if (cls_ff >= tbl_info.last_class || cls_ff >= LAST_SLOT) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_SIZE;
               rsp_grant_in  = '0;
               rsp_class_in  = '0;
               rsp_total_in  = '0;
               state_in      = S_IDLE;
            end else begin
               cls_in = cls_ff + CLS_W'(1);
            end
         end
         S_READ: begin
            head_in  = crd_valid_ff ? crd_ff.head       : '0;
            cnt_in   = crd_valid_ff ? crd_ff.free_count : '0;
            pages_in = crd_valid_ff ? crd_ff.page_count : '0;
            reqd_in  = crd_valid_ff ? crd_ff.requested  : '0;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            case (kind_ff)
               RT_FREE: begin
                  lwr_en   = 1'b1;
                  lwr_addr = caddr_ff[ALIGN_W +: LINK_W];
                  head_in  = caddr_ff[ALIGN_W +: LINK_W];
                  cnt_in   = cnt_ff + CNT_W'(1);
                  reqd_in  = reqd_ff - TOTAL_W'(size_ff);
                  state_in = S_WB;
               end
               RT_ADJUST: begin
                  reqd_in  = reqd_ff - TOTAL_W'(old_ff) + TOTAL_W'(new_ff);
                  state_in = S_WB;
               end
               default: begin
                  if (cnt_ff != '0) begin
                     state_in = S_POP;
                  end else begin
                     len_in   = SPAN_W'(tbl_chunk * tbl_cpp);
                     state_in = S_PCHK;
                  end
               end
            endcase
         end
         S_PCHK: begin
            if (len_ff == '0 || over_limit || len_ff > avail) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OOM;
               rsp_grant_in  = '0;
               rsp_class_in  = 6'(cls_ff);
               rsp_total_in  = reqd_ff;
               state_in      = S_IDLE;
            end else begin
               walk_in  = bump_ff;
               x_in     = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // chunks pushed in ascending order, one link write per cycle
            lwr_en  = 1'b1;
            head_in = walk_ff[ALIGN_W +: LINK_W];
            cnt_in  = cnt_ff + CNT_W'(1);
            walk_in = walk_ff + SPAN_W'(tbl_chunk);
            x_in    = x_ff + CPP_W'(1);
            if (x_in == tbl_cpp) begin
               bump_in  = bump_ff + step_len[SPAN_W-1:0];
               paged_in = paged_ff + len_ff;
               if (pages_ff != PAGES_MAX) pages_in = pages_ff + PAGES_W'(1);
               state_in = S_POP;
            end
         end
         S_POP: state_in = S_POP2;
         S_POP2: begin
            grant_in = 16'({head_ff, ALIGN_W'(0)});
            head_in  = lrd_ff;
            cnt_in   = cnt_ff - CNT_W'(1);
            reqd_in  = reqd_ff + TOTAL_W'(size_ff);
            state_in = S_WB;
         end
         S_WB: begin
            cwr_en        = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_grant_in  = grant_ff;
            rsp_class_in  = 6'(cls_ff);
            rsp_total_in  = reqd_ff;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bump_ff      <= '0;
         paged_ff     <= '0;
         cvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bump_ff      <= bump_in;
         paged_ff     <= paged_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cwr_en) cvalid_ff[cls_ff] <= 1'b1;
      end
      if (accept) begin
         kind_ff  <= req_kind_type'(req_type);
         size_ff  <= req_size_bytes;
         caddr_ff <= req_chunk_address;
         old_ff   <= req_old_bytes;
         new_ff   <= req_new_bytes;
      end
      cls_ff        <= cls_in;
      head_ff       <= head_in;
      cnt_ff        <= cnt_in;
      pages_ff      <= pages_in;
      reqd_ff       <= reqd_in;
      len_ff        <= len_in;
      walk_ff       <= walk_in;
      x_ff          <= x_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // class state memory: one read, one write port, registered read
   always_ff @(posedge clock) begin
      if (cwr_en) cmem[cls_ff] <= cwr_data;
      crd_ff       <= cmem[crd_addr];
      crd_valid_ff <= cvalid_ff[crd_addr];
   end

   // link memory: the pop read comes in the cycle after the last push
   always_ff @(posedge clock) begin
      if (lwr_en) lmem[lwr_addr] <= head_ff;
      lrd_ff <= lmem[head_ff];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_grant_ff;
   assign rsp_chosen_class    = rsp_class_ff;
   assign rsp_requested_total = rsp_total_ff;

   `SCA_ASSERT(a_strobe_idle, clock, reset, rsp_valid |-> state_ff == S_IDLE)
   `SCA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy || rsp_valid)
   `SCA_ASSERT(a_grant_aligned, clock, reset, rsp_valid |-> rsp_granted_address[ALIGN_W-1:0] == '0)
   `SCA_ASSERT(a_no_class_no_total, clock, reset,
      rsp_valid && rsp_chosen_class == '0 |-> rsp_requested_total == '0)

endmodule

// ===== rtl/core/sca_class_table.sv =====
// size class table: geometric build sequencer with serial divider
// depends on sca_pkg
module sca_class_table
   import sca_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rebuild,
   input  logic [12:0]        base_chunk_bytes,
   input  logic [GROW_W-1:0]  growth_factor_q8,
   input  logic [CLS_W-1:0]   rd_index,
   output logic [CHUNK_W-1:0] rd_chunk,
   output logic [CPP_W-1:0]   rd_cpp,
   output table_info_type     info
);

   typedef enum logic [6:0] {
      B_IDLE = 7'b0000001,
      B_INIT = 7'b0000010,
      B_MUL  = 7'b0000100,
      B_TEST = 7'b0001000,
      B_DIV  = 7'b0010000,
      B_NXT  = 7'b0100000,
      B_ADV  = 7'b1000000
   } build_state_type;

   build_state_type     state_ff, state_in;
   logic [CHUNK_W-1:0]  chunk_ff [CLASS_COUNT];
   logic [CPP_W-1:0]    cpp_ff [CLASS_COUNT];
   logic [CHUNK_W-1:0]  sz_ff, sz_in;
   logic [CHUNK_W-1:0]  al_ff, al_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [CLS_W-1:0]    idx_ff, idx_in;
   logic [CLS_W-1:0]    last_ff, last_in;
   logic [CHUNK_W:0]    rem_ff, rem_in;
   logic [CPP_W-1:0]    quo_ff, quo_in;
   logic [3:0]          step_ff, step_in;
   logic [CHUNK_W:0]    trial;
   logic [CHUNK_W:0]    sz_round;
   logic [CHUNK_W-1:0]  next_sz;

   assign trial    = {rem_ff[CHUNK_W-1:0], quo_ff[CPP_W-1]};
   assign sz_round = {1'b0, sz_ff} + (CHUNK_W+1)'(ALIGN_BYTES - 1);
   assign next_sz  = prod_ff[8 +: CHUNK_W];

   always_comb begin
      state_in = state_ff;
      sz_in    = sz_ff;
      al_in    = al_ff;
      prod_in  = prod_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      unique case (state_ff)
         B_IDLE: ;
         B_INIT: begin
            sz_in    = (base_chunk_bytes == '0) ? CHUNK_W'(1) : CHUNK_W'(base_chunk_bytes);
            idx_in   = CLS_W'(FIRST_CLASS);
            state_in = B_MUL;
         end
         B_MUL: begin
            prod_in  = PROD_W'(sz_ff) * PROD_W'(growth_factor_q8);
            state_in = B_TEST;
         end
         B_TEST: begin
            if (idx_ff >= LAST_SLOT || prod_ff > GROW_LIMIT) begin
               last_in  = idx_ff;
               state_in = B_IDLE;
            end else begin
               al_in    = CHUNK_W'(sz_round >> ALIGN_W << ALIGN_W);
               rem_in   = '0;
               quo_in   = CPP_W'(PAGE_BYTES);
               step_in  = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (trial >= {1'b0, al_ff}) begin
               rem_in = trial - {1'b0, al_ff};
               quo_in = {quo_ff[CPP_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[CPP_W-2:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(CPP_W - 1)) state_in = B_NXT;
         end
         B_NXT: begin
            prod_in  = PROD_W'(al_ff) * PROD_W'(growth_factor_q8);
            state_in = B_ADV;
         end
         B_ADV: begin
            sz_in    = (next_sz == '0) ? CHUNK_W'(1) : next_sz;
            idx_in   = idx_ff + CLS_W'(1);
            state_in = B_MUL;
         end
         default: state_in = B_IDLE;
      endcase
      if (rebuild) state_in = B_INIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_INIT;
         last_ff  <= CLS_W'(FIRST_CLASS);
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
      sz_ff   <= sz_in;
      al_ff   <= al_in;
      prod_ff <= prod_in;
      idx_ff  <= idx_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      // table entries are written as each class settles
      if (state_ff == B_TEST && (idx_ff >= LAST_SLOT || prod_ff > GROW_LIMIT)) begin
         chunk_ff[idx_ff] <= CHUNK_W'(PAGE_BYTES);
         cpp_ff[idx_ff]   <= CPP_W'(1);
      end else if (state_ff == B_NXT) begin
         chunk_ff[idx_ff] <= al_ff;
         cpp_ff[idx_ff]   <= quo_ff;
      end
   end

   assign rd_chunk        = chunk_ff[rd_index];
   assign rd_cpp          = cpp_ff[rd_index];
   assign info.building   = (state_ff != B_IDLE);
   assign info.last_class = last_ff;

endmodule

// ===== dv/slab_class_allocator_checker.sv =====
// checker for the slab class allocator: predicts every response and compares it
// depends on sca_pkg; watches the request, response and csr ports of the block
`timescale 1ns / 1ps
module slab_class_allocator_checker
   import sca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_size_bytes,
   input  logic [15:0] req_chunk_address,
   input  logic [5:0]  req_class_id,
   input  logic [15:0] req_old_bytes,
   input  logic [15:0] req_new_bytes,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_granted_address,
   input  logic [5:0]  rsp_chosen_class,
   input  logic [31:0] rsp_requested_total,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_write_data,
   output int          fail_count,
   output int          expected_left
);

   typedef struct {
      status_type  status;
      logic [15:0] address;
      logic [5:0]  cls;
      logic [31:0] total;
   } alloc_result_type;

   alloc_result_type awaited_results[$];

   logic [12:0] base_size;
   logic [10:0] growth_q8;
   logic [16:0] paged_cap;
   longint      chunk_size [CLASS_COUNT];
   longint      chunks_per_page [CLASS_COUNT];
   logic [13:0] list_head [CLASS_COUNT];
   logic [13:0] free_cnt [CLASS_COUNT];
   logic [4:0]  page_cnt [CLASS_COUNT];
   logic [31:0] req_total [CLASS_COUNT];
   logic [13:0] link_next [LINK_DEPTH];
   longint      bump_ptr;
   longint      paged_bytes;
   int          top_class;

   function automatic void rebuild_classes();
      longint sz;
      int     i;
      sz = base_size;
      i = FIRST_CLASS - 1;
      for (int k = 0; k < CLASS_COUNT; k++) begin
         chunk_size[k] = 0;
         chunks_per_page[k] = 0;
      end
      if (sz == 0) sz = 1;
      while (1) begin
         i++;
         if (i >= CLASS_COUNT - 1) break;
         if (sz * growth_q8 > longint'(PAGE_BYTES) * 256) break;
         if (sz % ALIGN_BYTES != 0) sz += ALIGN_BYTES - (sz % ALIGN_BYTES);
         chunk_size[i] = sz;
         chunks_per_page[i] = PAGE_BYTES / sz;
         sz = (sz * growth_q8) >> 8;
         if (sz == 0) sz = 1;
      end
      top_class = i;
      chunk_size[i] = PAGE_BYTES;
      chunks_per_page[i] = 1;
   endfunction

   function automatic void push_free(int id, logic [12:0] idx);
      link_next[idx] = list_head[id];
      list_head[id] = {1'b0, idx};
      free_cnt[id] = free_cnt[id] + 14'd1;
   endfunction

   function automatic bit carve_page(int id);
      longint len, avail, step;
      len = chunk_size[id] * chunks_per_page[id];
      avail = REGION_BYTES - bump_ptr;
      if (len == 0) return 0;
      if (paged_cap != 0 && paged_bytes + len > paged_cap && page_cnt[id] > 0) return 0;
      if (len > avail) return 0;
      for (longint x = 0; x < chunks_per_page[id]; x++)
         push_free(id, 13'(((bump_ptr + x * chunk_size[id]) / ALIGN_BYTES) % LINK_DEPTH));
      step = len;
      if (step % ALIGN_BYTES != 0) step += ALIGN_BYTES - (step % ALIGN_BYTES);
      if (step > avail) step = avail;
      bump_ptr += step;
      paged_bytes += len;
      if (page_cnt[id] != PAGES_MAX) page_cnt[id]++;
      return 1;
   endfunction

   function automatic int fit_class(longint size);
      int r;
      r = FIRST_CLASS;
      if (size == 0) return 0;
      while (size > chunk_size[r]) begin
         if (r >= top_class || r >= CLASS_COUNT - 1) return 0;
         r++;
      end
      return r;
   endfunction

   function automatic alloc_result_type predict_request();
      alloc_result_type res;
      int          c;
      int          id;
      logic [12:0] idx;
      res = '{ST_OK, 16'd0, 6'd0, 32'd0};
      id = req_class_id;
      if (req_kind_type'(req_type) == RT_ALLOC) begin
         c = fit_class(req_size_bytes);
         if (c == 0) begin
            res.status = ST_SIZE;
            return res;
         end
         res.cls = 6'(c);
         if (free_cnt[c] == 0) void'(carve_page(c));
         if (free_cnt[c] == 0) begin
            res.status = ST_OOM;
            res.total = req_total[c];
            return res;
         end
         idx = list_head[c][12:0];
         list_head[c] = link_next[idx];
         free_cnt[c] = free_cnt[c] - 14'd1;
         req_total[c] = req_total[c] + req_size_bytes;
         res.address = {idx, 3'b000};
         res.total = req_total[c];
         return res;
      end
      if (req_kind_type'(req_type) == RT_NONE || id < FIRST_CLASS || id > top_class
          || id >= CLASS_COUNT) begin
         res.status = ST_BAD_CLASS;
         return res;
      end
      if (req_kind_type'(req_type) == RT_FREE) begin
         push_free(id, req_chunk_address[15:3]);
         req_total[id] = req_total[id] - req_size_bytes;
      end else
         req_total[id] = req_total[id] - req_old_bytes + req_new_bytes;
      res.cls = 6'(id);
      res.total = req_total[id];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: response %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      expected_left = 0;
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         base_size = 13'd96;
         growth_q8 = 11'd320;
         paged_cap = 17'd0;
         for (int k = 0; k < CLASS_COUNT; k++) begin
            list_head[k] = '0;
            free_cnt[k] = '0;
            page_cnt[k] = '0;
            req_total[k] = '0;
         end
         bump_ptr = 0;
         paged_bytes = 0;
         rebuild_classes();
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: response strobe with no request outstanding", $realtime);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_granted_address != want.address)
                  report_mismatch("address", rsp_granted_address, want.address);
               if (rsp_chosen_class != want.cls)
                  report_mismatch("class", rsp_chosen_class, want.cls);
               if (rsp_requested_total != want.total)
                  report_mismatch("total", rsp_requested_total, want.total);
            end
         end
         if (start && !busy)
            awaited_results.push_back(predict_request());
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_BASE:   base_size = csr_write_data[12:0];
               CSR_GROWTH: growth_q8 = csr_write_data[10:0];
               CSR_LIMIT:  paged_cap = csr_write_data;
               default:    ;
            endcase
            if (csr_index_type'(csr_index) != CSR_NONE) rebuild_classes();
         end
      end
      expected_left = awaited_results.size();
   end

endmodule

// ===== dv/slab_class_allocator_top_tb.sv =====
// testbench top for the slab class allocator: clock, reset, stimulus and verdict
// depends on sca_pkg, slab_class_allocator_top and slab_class_allocator_checker
`timescale 1ns / 1ps
module slab_class_allocator_top_tb;
   import sca_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = RT_ALLOC;
   logic [15:0] req_size_bytes = '0;
   logic [15:0] req_chunk_address = '0;
   logic [5:0]  req_class_id = '0;
   logic [15:0] req_old_bytes = '0;
   logic [15:0] req_new_bytes = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_granted_address;
   logic [5:0]  rsp_chosen_class;
   logic [31:0] rsp_requested_total;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_BASE;
   logic [16:0] csr_write_data = '0;
   int          fail_count;
   int          expected_left;

   // chunks handed out so far, reused to build well-formed frees
   typedef struct {
      logic [15:0] address;
      logic [5:0]  cls;
      logic [15:0] size;
   } held_chunk_type;
   held_chunk_type held_chunks[$];
   req_kind_type   last_kind;
   logic [15:0]    last_size;
   bit             quiet_tail = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   slab_class_allocator_top u_top (.*);

   slab_class_allocator_checker u_checker (.*);

   // remember every chunk granted by an allocate
   always @(posedge clock)
      if (!reset && rsp_valid && last_kind == RT_ALLOC && rsp_status == ST_OK)
         held_chunks.push_back('{rsp_granted_address, rsp_chosen_class, last_size});

   // now and then hold start low for a random idle gap
   task automatic maybe_idle();
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // present one request and wait for the transfer; start stays high afterwards
   task automatic send_request(req_kind_type kind, logic [15:0] size, logic [15:0] addr,
                               logic [5:0] cls, logic [15:0] old_b, logic [15:0] new_b);
      maybe_idle();
      start <= 1'b1;
      req_type <= kind;
      req_size_bytes <= size;
      req_chunk_address <= addr;
      req_class_id <= cls;
      req_old_bytes <= old_b;
      req_new_bytes <= new_b;
      do @(posedge clock); while (busy);
      last_kind <= kind;
      last_size <= size;
   endtask

   // let every response arrive, then settle before touching the csr port
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // csr write while idle; the table rebuild holds busy high afterwards
   task automatic write_csr(csr_index_type idx, logic [16:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // weighted random sizes: mostly small classes, some pages, a few anything
   function automatic logic [15:0] pick_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 16'($urandom_range(1, 600));
      if (r < 9) return 16'($urandom_range(601, 4200));
      return 16'($urandom);
   endfunction

   task automatic random_request();
      int             r;
      int             pick;
      held_chunk_type h;
      r = $urandom_range(0, 99);
      if (r < 55)
         send_request(RT_ALLOC, pick_size(), 16'($urandom), 6'($urandom), 16'($urandom),
                      16'($urandom));
      else if (r < 85) begin
         if (held_chunks.size() != 0 && $urandom_range(0, 4) != 0) begin
            pick = $urandom_range(0, held_chunks.size() - 1);
            h = held_chunks[pick];
            held_chunks.delete(pick);
            send_request(RT_FREE, h.size, h.address, h.cls, 16'($urandom), 16'($urandom));
         end else
            send_request(RT_FREE, 16'($urandom), 16'($urandom), 6'($urandom),
                         16'($urandom), 16'($urandom));
      end else if (r < 97)
         send_request(RT_ADJUST, 16'($urandom), 16'($urandom),
                      ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 12)),
                      16'($urandom), 16'($urandom));
      else
         send_request(RT_NONE, 16'($urandom), 16'($urandom), 6'($urandom), 16'($urandom),
                      16'($urandom));
   endtask

   // settings per phase: default, slow growth with full cap, one class, mid, small base with no cap
   logic [12:0] phase_base [5]   = '{13'd96, 13'd1, 13'd4096, 13'd37, 13'd8};
   logic [10:0] phase_growth [5] = '{11'd320, 11'd257, 11'd1024, 11'd700, 11'd400};
   logic [16:0] phase_limit [5]  = '{17'd0, 17'd65536, 17'd4096, 17'd20000, 17'd0};

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed: size edges, class edges, each request kind, the unused kind
      send_request(RT_ALLOC, 16'd0, 16'd0, 6'd0, 16'd0, 16'd0);
      send_request(RT_ALLOC, 16'd1, 16'hFFFF, 6'h3F, 16'hFFFF, 16'hFFFF);
      send_request(RT_ALLOC, 16'd96, 16'd0, 6'd0, 16'd0, 16'd0);
      send_request(RT_ALLOC, 16'd97, 16'd0, 6'd0, 16'd0, 16'd0);
      send_request(RT_ALLOC, 16'd4096, 16'd0, 6'd0, 16'd0, 16'd0);
      send_request(RT_ALLOC, 16'd4097, 16'd0, 6'd0, 16'd0, 16'd0);
      send_request(RT_ALLOC, 16'hFFFF, 16'd0, 6'd0, 16'd0, 16'd0);
      send_request(RT_FREE, 16'd1, 16'hFFFF, 6'd1, 16'd0, 16'd0);
      send_request(RT_FREE, 16'd5, 16'd13, 6'd0, 16'd0, 16'd0);
      send_request(RT_FREE, 16'd5, 16'd13, 6'd31, 16'd0, 16'd0);
      send_request(RT_FREE, 16'd5, 16'd13, 6'd32, 16'd0, 16'd0);
      send_request(RT_FREE, 16'd5, 16'd13, 6'h3F, 16'd0, 16'd0);
      send_request(RT_ADJUST, 16'd0, 16'd0, 6'd2, 16'hFFFF, 16'd0);
      send_request(RT_ADJUST, 16'd0, 16'd0, 6'd2, 16'd0, 16'hFFFF);
      send_request(RT_ADJUST, 16'd0, 16'd0, 6'd0, 16'd1, 16'd2);
      send_request(RT_ALLOC, 16'd1, 16'd0, 6'd0, 16'd0, 16'd0);
      send_request(RT_NONE, 16'hFFFF, 16'hFFFF, 6'd1, 16'hFFFF, 16'hFFFF);

      for (int p = 0; p < 5; p++) begin
         drain();
         write_csr(CSR_BASE, 17'(phase_base[p]));
         write_csr(CSR_GROWTH, 17'(phase_growth[p]));
         write_csr(CSR_LIMIT, phase_limit[p]);
         for (int n = 0; n < 80; n++) begin
            // last stretch of the run goes without idle gaps
            if (p == 4 && n == 40) quiet_tail = 1;
            random_request();
         end
      end

      start <= 1'b0;
      while (expected_left != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("** slab_class_allocator_top: PASSED **");
      else
         $display("** slab_class_allocator_top: FAILED **");
      $finish;
   end

   // watchdog against a hung handshake
   initial begin
      #20ms;
      $display("** slab_class_allocator_top: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sca_pkg.sv
rtl/core/sca_class_table.sv
rtl/core/slab_class_allocator_top.sv
dv/slab_class_allocator_checker.sv
dv/slab_class_allocator_top_tb.sv
